### hw/rtl/buddhabrot_orbit_accumulator_macros.svh
// Assertion helpers used by the checker file bob_chk.sv.
`ifndef BUDDHABROT_ORBIT_ACCUMULATOR_MACROS_SVH
`define BUDDHABROT_ORBIT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define BOB_ASSERT_NOW(lbl, ck, dis, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BOB_ASSERT_NEXT(lbl, ck, dis, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bob_pkg.sv
package bob_pkg;

  localparam int GRID_W_DEF     = 256;
  localparam int GRID_H_DEF     = 256;
  localparam int COUNT_BITS_DEF = 32;

  localparam int FRAC    = 28;
  localparam int Z_BITS  = 34;
  localparam int M_BITS  = 31;
  localparam int P_BITS  = 62;

  localparam logic [15:0] ITER_LIM_RST = 16'd10000;
  localparam logic [15:0] SCALE_X_RST  = 16'd91;
  localparam logic [15:0] SCALE_Y_RST  = 16'd98;
  localparam logic [30:0] OFFSET_X_RST = 31'd536870912;
  localparam logic [30:0] OFFSET_Y_RST = 31'd348966093;

  typedef enum logic [2:0] {
    CFG_ITER_LIM = 3'd0,
    CFG_SCALE_X  = 3'd1,
    CFG_SCALE_Y  = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4
  } cfg_idx_t;

  typedef enum logic [0:0] {
    FUNC_TRACE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [7:0]         bin_x;
    logic [7:0]         bin_y;
  } in_item_t;

  typedef struct packed {
    logic        escaped;
    logic [15:0] iter_count;
    logic [31:0] bin_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_E_MUL,
    ST_E_TST,
    ST_E_ADV,
    ST_O_MUL,
    ST_O_RD,
    ST_O_WR,
    ST_R_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic mul;
    logic adv;
    logic esc_set;
    logic orb_start;
    logic rd_bin;
    logic wr_bin;
    logic rd_req;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic func;
    logic max_zero;
    logic outside;
    logic n_at_max;
    logic j_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/bob_ram.sv
module bob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bob_ctrl.sv
module bob_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bob_pkg::sts_t sts,
  output bob_pkg::cmd_t cmd
);

  bob_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bob_pkg::ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      bob_pkg::ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = bob_pkg::ST_IDLE;
      end
      bob_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.func == bob_pkg::FUNC_READ) state_next = bob_pkg::ST_R_RD;
          else if (sts.max_zero) state_next = bob_pkg::ST_DONE;
          else state_next = bob_pkg::ST_E_MUL;
        end
      end
      bob_pkg::ST_E_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bob_pkg::ST_E_TST;
      end
      bob_pkg::ST_E_TST: begin
        if (sts.outside) begin
          cmd.esc_set   = 1'b1;
          cmd.orb_start = 1'b1;
          state_next    = bob_pkg::ST_O_MUL;
        end else if (sts.n_at_max) begin
          state_next = bob_pkg::ST_DONE;
        end else begin
          state_next = bob_pkg::ST_E_ADV;
        end
      end
      bob_pkg::ST_E_ADV: begin
        cmd.adv    = 1'b1;
        state_next = bob_pkg::ST_E_MUL;
      end
      bob_pkg::ST_O_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bob_pkg::ST_O_RD;
      end
      bob_pkg::ST_O_RD: begin
        cmd.rd_bin = 1'b1;
        state_next = bob_pkg::ST_O_WR;
      end
      bob_pkg::ST_O_WR: begin
        cmd.wr_bin = 1'b1;
        state_next = sts.j_last ? bob_pkg::ST_DONE : bob_pkg::ST_O_MUL;
      end
      bob_pkg::ST_R_RD: begin
        cmd.rd_req = 1'b1;
        state_next = bob_pkg::ST_DONE;
      end
      bob_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bob_pkg::ST_IDLE;
        end
      end
      default: state_next = bob_pkg::ST_CLR;
    endcase
  end

endmodule

### hw/rtl/bob_dp.sv
module bob_dp #(
  parameter int GRID_W     = bob_pkg::GRID_W_DEF,
  parameter int GRID_H     = bob_pkg::GRID_H_DEF,
  parameter int COUNT_BITS = bob_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bob_pkg::in_item_t in_data,
  input  logic              out_stall,
  output logic              out_valid,
  output bob_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [30:0]       cfg_data,
  input  bob_pkg::cmd_t     cmd,
  output bob_pkg::sts_t     sts
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int FRAC  = bob_pkg::FRAC;
  localparam int ZW    = bob_pkg::Z_BITS;
  localparam int MW    = bob_pkg::M_BITS;
  localparam int PW    = bob_pkg::P_BITS;
  localparam int PXW   = ZW + 18;
  localparam int BW    = PXW - FRAC;

  localparam logic signed [ZW-1:0] ZLIM = ZW'(2) <<< FRAC;
  localparam logic [PW:0]          RLIM = (PW+1)'(1) << (2 * FRAC + 2);

  logic [15:0] iter_lim, scale_x, scale_y;
  logic [30:0] offset_x, offset_y;

  logic signed [31:0] c_re, c_im;
  logic               func;
  logic [7:0]         bx, by;
  logic               req_ok;

  logic signed [ZW-1:0] re, im;
  logic [15:0]          n, j;
  logic                 esc;
  logic signed [PW-1:0] aa, bb, ab;
  logic                 inr, nz;
  logic signed [PXW-1:0] px, py;
  logic [AW-1:0]        bin_addr;
  logic                 hit;
  logic [AW-1:0]        clr_cnt;

  logic [COUNT_BITS-1:0] rdata, inc;
  logic [63:0]           rdata_w;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_lim <= bob_pkg::ITER_LIM_RST;
      scale_x  <= bob_pkg::SCALE_X_RST;
      scale_y  <= bob_pkg::SCALE_Y_RST;
      offset_x <= bob_pkg::OFFSET_X_RST;
      offset_y <= bob_pkg::OFFSET_Y_RST;
    end else if (cfg_we) begin
      case (bob_pkg::cfg_idx_t'(cfg_addr))
        bob_pkg::CFG_ITER_LIM: iter_lim <= cfg_data[15:0];
        bob_pkg::CFG_SCALE_X:  scale_x  <= cfg_data[15:0];
        bob_pkg::CFG_SCALE_Y:  scale_y  <= cfg_data[15:0];
        bob_pkg::CFG_OFFSET_X: offset_x <= cfg_data;
        bob_pkg::CFG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // next orbit point from registered products
  logic signed [PW:0]   dif, dif_sh;
  logic signed [PW-1:0] ab_sh;
  logic signed [ZW-1:0] re_n, im_n;
  logic [PW:0]          mag;

  assign dif    = (PW+1)'(aa) - (PW+1)'(bb);
  assign dif_sh = dif >>> FRAC;
  assign ab_sh  = ab >>> (FRAC - 1);
  assign re_n   = ZW'(dif_sh) + ZW'(c_re);
  assign im_n   = ZW'(ab_sh) + ZW'(c_im);
  assign mag    = {1'b0, aa} + {1'b0, bb};

  // multiplier inputs
  logic signed [MW-1:0] am, bm;
  logic signed [ZW:0]   sumx, sumy;

  assign am   = $signed(re[MW-1:0]);
  assign bm   = $signed(im[MW-1:0]);
  assign sumx = (ZW+1)'(re) + $signed({{(ZW-30){1'b0}}, offset_x});
  assign sumy = (ZW+1)'(im) + $signed({{(ZW-30){1'b0}}, offset_y});

  // bin index from registered bin products
  logic signed [PXW-1:0] xs, ys;
  logic [BW-1:0]         xb, yb;
  logic                  x_ok, y_ok;
  logic [AW-1:0]         bin_addr_c, req_addr;

  assign xs   = px >>> FRAC;
  assign ys   = py >>> FRAC;
  assign xb   = xs[BW-1:0];
  assign yb   = ys[BW-1:0];
  assign x_ok = !xb[BW-1] && (xb[BW-2:0] < (BW-1)'(GRID_W));
  assign y_ok = !yb[BW-1] && (yb[BW-2:0] < (BW-1)'(GRID_H));
  assign bin_addr_c = AW'(64'(yb[BW-2:0]) * 64'(GRID_W) + 64'(xb[BW-2:0]));
  assign req_addr   = AW'(64'(by) * 64'(GRID_W) + 64'(bx));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re   <= in_data.c_real;
      c_im   <= in_data.c_imag;
      func   <= in_data.func;
      bx     <= in_data.bin_x;
      by     <= in_data.bin_y;
      req_ok <= (32'(in_data.bin_x) < GRID_W) && (32'(in_data.bin_y) < GRID_H);
      re     <= '0;
      im     <= '0;
      n      <= '0;
    end else if (cmd.adv) begin
      re <= re_n;
      im <= im_n;
      n  <= n + 16'd1;
    end else if (cmd.orb_start) begin
      re <= '0;
      im <= '0;
      j  <= '0;
    end else if (cmd.wr_bin) begin
      re <= re_n;
      im <= im_n;
      j  <= j + 16'd1;
    end
    if (cmd.mul) begin
      aa  <= am * am;
      bb  <= bm * bm;
      ab  <= am * bm;
      inr <= (re <= ZLIM) && (re >= -ZLIM) && (im <= ZLIM) && (im >= -ZLIM);
      nz  <= (re != '0) && (im != '0);
      px  <= sumx * $signed({1'b0, scale_x});
      py  <= sumy * $signed({1'b0, scale_y});
    end
    if (cmd.rd_bin) begin
      bin_addr <= bin_addr_c;
      hit      <= nz && x_ok && y_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc     <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.load) esc <= 1'b0;
      else if (cmd.esc_set) esc <= 1'b1;
    end
  end

  // histogram memory
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  assign inc       = (rdata == '1) ? rdata : rdata + COUNT_BITS'(1);
  assign ram_we    = cmd.clr || (cmd.wr_bin && hit);
  assign ram_waddr = cmd.clr ? clr_cnt : bin_addr;
  assign ram_wdata = cmd.clr ? '0 : inc;
  assign ram_re    = cmd.rd_bin || cmd.rd_req;
  assign ram_raddr = cmd.rd_req ? req_addr : bin_addr_c;

  bob_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign rdata_w = 64'(rdata);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.escaped    <= (func == bob_pkg::FUNC_READ) ? 1'b0 : esc;
      out_data.iter_count <= (func == bob_pkg::FUNC_READ) ? 16'd0 : n;
      out_data.bin_count  <= (func == bob_pkg::FUNC_READ && req_ok) ? rdata_w[31:0] : 32'd0;
    end
  end

  assign sts.clr_last = (clr_cnt == AW'(DEPTH - 1));
  assign sts.func     = in_data.func;
  assign sts.max_zero = (iter_lim == 16'd0);
  assign sts.outside  = !inr || (mag > RLIM);
  assign sts.n_at_max = (n == iter_lim);
  assign sts.j_last   = ((j + 16'd1) == n);
  assign sts.out_free = !out_valid || !out_stall;

endmodule

### hw/rtl/buddhabrot_orbit_accumulator.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_data  (bob_pkg::in_item_t)
// out       out_valid / out_stall out_data (bob_pkg::out_item_t)
// cfg       cfg_we               cfg_addr, cfg_data
//
// From the accepting cycle to the result load a trace item runs escape steps until it
// escapes or reaches its limit, then orbit steps if it escaped, and none with a zero limit; an
// escape step is a multiply, a test and an add cycle, an orbit step a multiply, a
// histogram read and a read-modify-write cycle through the single RAM.
// A read item is a RAM read. One item is worked on at a time; a stalled result adds its wait.
// After reset a clearing pass writes zero to every bin, GRID_W*GRID_H of them (65536 by
// default), with in_stall high; configuration writes are taken throughout.
// A finished result waits in the output register while the next item is accepted.
module buddhabrot_orbit_accumulator #(
  parameter int GRID_W     = bob_pkg::GRID_W_DEF,
  parameter int GRID_H     = bob_pkg::GRID_H_DEF,
  parameter int COUNT_BITS = bob_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bob_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bob_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [30:0]        cfg_data
);

  bob_pkg::cmd_t cmd;
  bob_pkg::sts_t sts;

  bob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bob_dp #(
    .GRID_W     (GRID_W),
    .GRID_H     (GRID_H),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### hw/rtl/bob_chk.sv
`include "buddhabrot_orbit_accumulator_macros.svh"

module bob_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bob_pkg::out_item_t out_data
);

  logic in_take, out_hold, read_beat, trace_zero, esc_beat;
  assign in_take    = in_valid && !in_stall;
  assign out_hold   = out_valid && out_stall;
  assign read_beat  = out_valid && (out_data.bin_count != 32'd0);
  assign trace_zero = !out_data.escaped && (out_data.iter_count == 16'd0);
  assign esc_beat   = out_valid && out_data.escaped;

  `BOB_ASSERT_NEXT(a_clear_after_reset, clk, 1'b0, rst, in_stall, "input open during clear")
  `BOB_ASSERT_NEXT(a_busy_after_take, clk, rst, in_take, in_stall, "beat taken while busy")
  `BOB_ASSERT_NEXT(a_out_hold, clk, rst, out_hold, out_valid && $stable(out_data), "beat changed")
  `BOB_ASSERT_NOW(a_read_fields, clk, rst, read_beat, trace_zero, "read with trace fields")
  `BOB_ASSERT_NOW(a_escape_steps, clk, rst, esc_beat, out_data.iter_count != 16'd0, "no steps")

endmodule

bind buddhabrot_orbit_accumulator bob_chk u_chk (.*);
